FILE: design/pbb_pkg.sv
`default_nettype none
package pbb_pkg;

  localparam int MW    = 32;
  localparam int CW    = 18;
  localparam int PW    = MW + CW;
  localparam int SW    = PW + 2;
  localparam int SHIFT = 12;
  localparam int NW    = SW + SHIFT;
  localparam int DW    = SW;
  localparam int QW    = 42;
  localparam int EW    = QW + 2;
  localparam int FW    = 42;
  localparam int CIW   = 3;

  localparam longint LIM40 = 64'sd1 <<< 40;

  localparam logic [63:0] R0AB_RST = 64'h0001_0000_0000_0000;
  localparam logic [63:0] R0CR1A_RST = 64'h0;
  localparam logic [63:0] R1BC_RST = 64'h0001_0000_0000_0000;
  localparam logic [63:0] R2AB_RST = 64'h0;
  localparam logic [31:0] R2C_RST = 32'h1000_0000;

  typedef enum logic [CIW-1:0] {
    CFG_ROW0_AB      = 3'd0,
    CFG_ROW0_C_ROW1A = 3'd1,
    CFG_ROW1_BC      = 3'd2,
    CFG_ROW2_AB      = 3'd3,
    CFG_ROW2_C       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic        [15:0] box_width;
    logic        [15:0] box_height;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic        [15:0] out_width;
    logic        [15:0] out_height;
    logic               degenerate;
  } out_word_t;

  typedef struct packed {
    logic       zero;
    logic [7:0] neg;
    logic [7:0] ovf;
  } side_t;

endpackage
`default_nettype wire

FILE: design/pbb_in_if.sv
`default_nettype none
interface pbb_in_if;
  import pbb_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/pbb_out_if.sv
`default_nettype none
interface pbb_out_if;
  import pbb_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/pbb_div.sv
`default_nettype none
module pbb_div import pbb_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QW-1:0] quo_o,
  output logic               rem_nz_o
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = DW'(num_i[NW-1:QW]);
      assign low_in = num_i[QW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        low_q[k] <= {low_in[QW-2:0], 1'b0};
        quo_q[k] <= {quo_in[QW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o    = quo_q[QW-1];
  assign rem_nz_o = |rem_q[QW-1];

endmodule
`default_nettype wire

FILE: design/projective_box_bounds.sv
// one word per cycle: a new box may enter every cycle while
// the output is not stalled
// the restoring dividers give one quotient bit per stage
// a stalled output holds the whole pipeline in place
// reset clears all valid bits and loads the identity matrix
`default_nettype none
module projective_box_bounds import pbb_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [CIW-1:0] cfg_idx_i,
  input  wire logic [63:0]    cfg_data_i,
  pbb_in_if.sink              in_i,
  pbb_out_if.source           out_o
);

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  function automatic logic signed [FW-1:0] lim40(input logic signed [EW-1:0] v);
    if (v > LIM40) return FW'(LIM40);
    if (v < -LIM40) return FW'(-LIM40);
    return FW'(v);
  endfunction

  logic [63:0] r0ab_q, r0cr1a_q, r1bc_q, r2ab_q;
  logic [31:0] r2c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0ab_q   <= R0AB_RST;
      r0cr1a_q <= R0CR1A_RST;
      r1bc_q   <= R1BC_RST;
      r2ab_q   <= R2AB_RST;
      r2c_q    <= R2C_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW0_AB:      r0ab_q   <= cfg_data_i;
        CFG_ROW0_C_ROW1A: r0cr1a_q <= cfg_data_i;
        CFG_ROW1_BC:      r1bc_q   <= cfg_data_i;
        CFG_ROW2_AB:      r2ab_q   <= cfg_data_i;
        CFG_ROW2_C:       r2c_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic signed [MW-1:0] coef [9];
  assign coef[0] = $signed(r0ab_q[63:32]);
  assign coef[1] = $signed(r0ab_q[31:0]);
  assign coef[2] = $signed(r0cr1a_q[63:32]);
  assign coef[3] = $signed(r0cr1a_q[31:0]);
  assign coef[4] = $signed(r1bc_q[63:32]);
  assign coef[5] = $signed(r1bc_q[31:0]);
  assign coef[6] = $signed(r2ab_q[63:32]);
  assign coef[7] = $signed(r2ab_q[31:0]);
  assign coef[8] = $signed(r2c_q);

  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // corners
  logic s1_vld_q;
  logic signed [CW-1:0] cx_q [2], cy_q [2];
  logic signed [CW-1:0] cx_d [2], cy_d [2];

  always_comb begin
    cx_d[0] = -$signed({{(CW-16){in_i.data.origin_x[15]}}, in_i.data.origin_x});
    cy_d[0] = -$signed({{(CW-16){in_i.data.origin_y[15]}}, in_i.data.origin_y});
    cx_d[1] = cx_d[0] + $signed({{(CW-16){1'b0}}, in_i.data.box_width}) - CW'(1);
    cy_d[1] = cy_d[0] + $signed({{(CW-16){1'b0}}, in_i.data.box_height}) - CW'(1);
  end

  // products
  logic s2_vld_q;
  logic signed [PW-1:0] prod_q [4][6], prod_d [4][6];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      prod_d[c][0] = coef[0] * cx_q[c & 1];
      prod_d[c][1] = coef[1] * cy_q[c >> 1];
      prod_d[c][2] = coef[3] * cx_q[c & 1];
      prod_d[c][3] = coef[4] * cy_q[c >> 1];
      prod_d[c][4] = coef[6] * cx_q[c & 1];
      prod_d[c][5] = coef[7] * cy_q[c >> 1];
    end
  end

  // sums
  logic s3_vld_q;
  logic signed [SW-1:0] sum_q [4][3], sum_d [4][3];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_d[c][0] = SW'(prod_q[c][0]) + SW'(prod_q[c][1]) + SW'(coef[2]);
      sum_d[c][1] = SW'(prod_q[c][2]) + SW'(prod_q[c][3]) + SW'(coef[5]);
      sum_d[c][2] = SW'(prod_q[c][4]) + SW'(prod_q[c][5]) + SW'(coef[8]);
    end
  end

  // magnitudes and signs
  logic s4_vld_q;
  logic [NW-1:0] num_q [8], num_d [8];
  logic [DW-1:0] den_q [4], den_d [4];
  side_t side_d, side_s4_q;

  always_comb begin
    logic [SW-1:0] na;
    side_d = '0;
    for (int c = 0; c < 4; c++) begin
      den_d[c] = mag(sum_q[c][2]);
      side_d.zero = side_d.zero | (sum_q[c][2] == '0);
      for (int k = 0; k < 2; k++) begin
        na = mag(sum_q[c][k]);
        num_d[2*c+k] = {na, {SHIFT{1'b0}}};
        side_d.neg[2*c+k] = sum_q[c][k][SW-1] ^ sum_q[c][2][SW-1];
        side_d.ovf[2*c+k] = DW'(num_d[2*c+k][NW-1:QW]) >= den_d[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      prod_q    <= prod_d;
      sum_q     <= sum_d;
      num_q     <= num_d;
      den_q     <= den_d;
      side_s4_q <= side_d;
    end
  end

  // dividers, side bits travel alongside
  logic [QW-1:0] quo [8];
  logic [7:0]    rnz;

  for (genvar k = 0; k < 8; k++) begin : g_div
    pbb_div u_div (
      .clk_i    (clk_i),
      .en_i     (en),
      .num_i    (num_q[k]),
      .den_i    (den_q[k/2]),
      .quo_o    (quo[k]),
      .rem_nz_o (rnz[k])
    );
  end

  logic [QW-1:0] dl_vld_q;
  side_t         dl_side_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_vld_q <= '0;
    end else if (en) begin
      dl_vld_q <= {dl_vld_q[QW-2:0], s4_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_side_q[0] <= side_s4_q;
      for (int k = 1; k < QW; k++) dl_side_q[k] <= dl_side_q[k-1];
    end
  end

  // floor and ceil
  logic p_vld_q, p_zero_q;
  logic signed [FW-1:0] fl_q [8], ce_q [8], fl_d [8], ce_d [8];
  side_t ds;
  assign ds = dl_side_q[QW-1];

  always_comb begin
    logic signed [EW-1:0] qe, rz, fv, cv;
    for (int k = 0; k < 8; k++) begin
      qe = $signed(EW'(quo[k]));
      rz = $signed(EW'(rnz[k]));
      if (ds.ovf[k]) begin
        fv = ds.neg[k] ? EW'(-LIM40) : EW'(LIM40);
        cv = fv;
      end else if (ds.neg[k]) begin
        fv = -(qe + rz);
        cv = -qe;
      end else begin
        fv = qe;
        cv = qe + rz;
      end
      fl_d[k] = lim40(fv);
      ce_d[k] = lim40(cv);
    end
  end

  // min and max tree
  logic a_vld_q, a_zero_q, b_vld_q, b_zero_q;
  logic signed [FW-1:0] mnx_a_q [2], mxx_a_q [2], mny_a_q [2], mxy_a_q [2];
  logic signed [FW-1:0] mnx_b_q, mxx_b_q, mny_b_q, mxy_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q   <= 1'b0;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q   <= dl_vld_q[QW-1];
      a_vld_q   <= p_vld_q;
      b_vld_q   <= a_vld_q;
      out_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_zero_q <= ds.zero;
      fl_q     <= fl_d;
      ce_q     <= ce_d;
      a_zero_q <= p_zero_q;
      for (int p = 0; p < 2; p++) begin
        mnx_a_q[p] <= (fl_q[4*p] < fl_q[4*p+2]) ? fl_q[4*p] : fl_q[4*p+2];
        mxx_a_q[p] <= (ce_q[4*p] > ce_q[4*p+2]) ? ce_q[4*p] : ce_q[4*p+2];
        mny_a_q[p] <= (fl_q[4*p+1] < fl_q[4*p+3]) ? fl_q[4*p+1] : fl_q[4*p+3];
        mxy_a_q[p] <= (ce_q[4*p+1] > ce_q[4*p+3]) ? ce_q[4*p+1] : ce_q[4*p+3];
      end
      b_zero_q <= a_zero_q;
      mnx_b_q  <= (mnx_a_q[0] < mnx_a_q[1]) ? mnx_a_q[0] : mnx_a_q[1];
      mxx_b_q  <= (mxx_a_q[0] > mxx_a_q[1]) ? mxx_a_q[0] : mxx_a_q[1];
      mny_b_q  <= (mny_a_q[0] < mny_a_q[1]) ? mny_a_q[0] : mny_a_q[1];
      mxy_b_q  <= (mxy_a_q[0] > mxy_a_q[1]) ? mxy_a_q[0] : mxy_a_q[1];
    end
  end

  // saturation and output word
  out_word_t out_q, out_d;

  always_comb begin
    logic signed [EW-1:0] szx, szy;
    logic                 deg;
    deg  = 1'b0;
    szx  = EW'(mxx_b_q) - EW'(mnx_b_q) + EW'(1);
    szy  = EW'(mxy_b_q) - EW'(mny_b_q) + EW'(1);
    out_d = '0;
    if (mnx_b_q < -FW'(32768)) begin
      deg = 1'b1;
      out_d.out_x = 16'sh8000;
    end else if (mnx_b_q > FW'(32767)) begin
      deg = 1'b1;
      out_d.out_x = 16'sh7fff;
    end else begin
      out_d.out_x = mnx_b_q[15:0];
    end
    if (mny_b_q < -FW'(32768)) begin
      deg = 1'b1;
      out_d.out_y = 16'sh8000;
    end else if (mny_b_q > FW'(32767)) begin
      deg = 1'b1;
      out_d.out_y = 16'sh7fff;
    end else begin
      out_d.out_y = mny_b_q[15:0];
    end
    if (szx > EW'(65535)) begin
      deg = 1'b1;
      out_d.out_width = 16'hffff;
    end else if (szx < EW'(1)) begin
      out_d.out_width = 16'd1;
    end else begin
      out_d.out_width = szx[15:0];
    end
    if (szy > EW'(65535)) begin
      deg = 1'b1;
      out_d.out_height = 16'hffff;
    end else if (szy < EW'(1)) begin
      out_d.out_height = 16'd1;
    end else begin
      out_d.out_height = szy[15:0];
    end
    out_d.degenerate = deg;
    if (b_zero_q) begin
      out_d.out_x      = 16'sh8000;
      out_d.out_y      = 16'sh8000;
      out_d.out_width  = 16'hffff;
      out_d.out_height = 16'hffff;
      out_d.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

`ifndef SYNTH
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_i.ready)
    else $error("input not ready with empty output stage");
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_vld_q)
    else $error("accepted word lost at entry");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> (s1_vld_q == $past(s1_vld_q)) && p_vld_q == $past(p_vld_q))
    else $error("pipeline moved during stall");
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.out_width != 16'd0) && (out_q.out_height != 16'd0))
    else $error("zero size in result word");
`endif

endmodule
`default_nettype wire

FILE: dv/pbb_checker.sv
`timescale 1ns / 100ps
module pbb_checker import pbb_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [CIW-1:0] cfg_idx_i,
  input  wire logic [63:0]    cfg_data_i,
  input  wire logic           in_valid_i,
  input  wire logic           in_ready_i,
  input  wire in_word_t       in_data_i,
  input  wire logic           out_valid_i,
  input  wire logic           out_ready_i,
  input  wire out_word_t      out_data_i,
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);

  logic [63:0] row0_ab, row0_c_row1_a, row1_bc, row2_ab;
  logic [31:0] row2_c;
  out_word_t   bounds_q[$];

  function automatic longint hi(logic [63:0] r);
    return longint'($signed(r[63:32]));
  endfunction

  function automatic longint lo(logic [63:0] r);
    return longint'($signed(r[31:0]));
  endfunction

  // exact floor and ceiling of n / d
  function automatic void div_round(longint n, longint d, output longint fl,
                                    output longint ce);
    longint q, r;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    q  = n / d;
    r  = n % d;
    fl = (r != 0 && n < 0) ? q - 1 : q;
    ce = (r != 0 && n > 0) ? q + 1 : q;
  endfunction

  function automatic longint clamp40(longint v);
    if (v > LIM40) return LIM40;
    if (v < -LIM40) return -LIM40;
    return v;
  endfunction

  function automatic logic [15:0] sat_pos(longint v, ref logic deg);
    if (v < -32768) begin
      deg = 1'b1;
      v = -32768;
    end
    if (v > 32767) begin
      deg = 1'b1;
      v = 32767;
    end
    return v[15:0];
  endfunction

  function automatic logic [15:0] sat_size(longint v, ref logic deg);
    if (v > 65535) begin
      deg = 1'b1;
      v = 65535;
    end
    if (v < 1) v = 1;
    return v[15:0];
  endfunction

  function automatic out_word_t warp_bounds(in_word_t w);
    longint    m00, m01, m02, m10, m11, m12, m20, m21, m22;
    longint    xs[2], ys[2];
    longint    cx, cy, px, py, pw, fx, cxv, fy, cyv;
    longint    minx, maxx, miny, maxy;
    logic      deg;
    out_word_t res;
    m00 = hi(row0_ab);
    m01 = lo(row0_ab);
    m02 = hi(row0_c_row1_a);
    m10 = lo(row0_c_row1_a);
    m11 = hi(row1_bc);
    m12 = lo(row1_bc);
    m20 = hi(row2_ab);
    m21 = lo(row2_ab);
    m22 = longint'($signed(row2_c));
    xs[0] = -longint'(w.origin_x);
    ys[0] = -longint'(w.origin_y);
    xs[1] = xs[0] + longint'({48'd0, w.box_width}) - 1;
    ys[1] = ys[0] + longint'({48'd0, w.box_height}) - 1;
    minx = 0; maxx = 0; miny = 0; maxy = 0;
    deg = 1'b0;
    for (int i = 0; i < 4; i++) begin
      cx = xs[i & 1];
      cy = ys[i >> 1];
      px = m00 * cx + m01 * cy + m02;
      py = m10 * cx + m11 * cy + m12;
      pw = m20 * cx + m21 * cy + m22;
      if (pw == 0) begin
        res.out_x      = 16'h8000;
        res.out_y      = 16'h8000;
        res.out_width  = 16'hffff;
        res.out_height = 16'hffff;
        res.degenerate = 1'b1;
        return res;
      end
      div_round(px * 4096, pw, fx, cxv);
      div_round(py * 4096, pw, fy, cyv);
      fx = clamp40(fx);
      cxv = clamp40(cxv);
      fy = clamp40(fy);
      cyv = clamp40(cyv);
      if (i == 0 || fx < minx) minx = fx;
      if (i == 0 || cxv > maxx) maxx = cxv;
      if (i == 0 || fy < miny) miny = fy;
      if (i == 0 || cyv > maxy) maxy = cyv;
    end
    res.out_x      = sat_pos(minx, deg);
    res.out_y      = sat_pos(miny, deg);
    res.out_width  = sat_size(maxx - minx + 1, deg);
    res.out_height = sat_size(maxy - miny + 1, deg);
    res.degenerate = deg;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      row0_ab       <= R0AB_RST;
      row0_c_row1_a <= R0CR1A_RST;
      row1_bc       <= R1BC_RST;
      row2_ab       <= R2AB_RST;
      row2_c        <= R2C_RST;
      bounds_q.delete();
      pending_o     <= 0;
      fail_count_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROW0_AB:      row0_ab       <= cfg_data_i;
          CFG_ROW0_C_ROW1A: row0_c_row1_a <= cfg_data_i;
          CFG_ROW1_BC:      row1_bc       <= cfg_data_i;
          CFG_ROW2_AB:      row2_ab       <= cfg_data_i;
          CFG_ROW2_C:       row2_c        <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) bounds_q.push_back(warp_bounds(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (bounds_q.size() == 0) begin
          $error("unexpected result word %h", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = bounds_q.pop_front();
          if (out_data_i !== exp_w) begin
            if (out_data_i.out_x !== exp_w.out_x)
              $error("out_x: expected %0d actual %0d", exp_w.out_x, out_data_i.out_x);
            if (out_data_i.out_y !== exp_w.out_y)
              $error("out_y: expected %0d actual %0d", exp_w.out_y, out_data_i.out_y);
            if (out_data_i.out_width !== exp_w.out_width)
              $error("out_width: expected %0d actual %0d", exp_w.out_width,
                     out_data_i.out_width);
            if (out_data_i.out_height !== exp_w.out_height)
              $error("out_height: expected %0d actual %0d", exp_w.out_height,
                     out_data_i.out_height);
            if (out_data_i.degenerate !== exp_w.degenerate)
              $error("degenerate: expected %0b actual %0b", exp_w.degenerate,
                     out_data_i.degenerate);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= unsigned'(bounds_q.size());
    end
  end

endmodule

FILE: dv/tb_projective_box_bounds.sv
`timescale 1ns / 100ps
module tb_projective_box_bounds;
  import pbb_pkg::*;

  localparam int CycleLimit = 1000000;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [CIW-1:0] cfg_idx_i;
  logic [63:0]    cfg_data_i;
  int unsigned    pending, fail_count, cycles;
  bit             send_idle, recv_idle;

  pbb_in_if  in_if ();
  pbb_out_if out_if ();

  projective_box_bounds u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  pbb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_data_i    (in_if.data),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_data_i   (out_if.data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side stalls
  initial begin
    bit hs;
    int g;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      g = recv_idle ? $urandom_range(0, 13) : 0;
      if (g > 0) begin
        out_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do begin
        @(negedge clk_i) hs = out_if.valid;
        @(posedge clk_i);
      end while (!hs);
    end
  end

  task automatic write_matrix(logic [31:0] m00, logic [31:0] m01, logic [31:0] m02,
                              logic [31:0] m10, logic [31:0] m11, logic [31:0] m12,
                              logic [31:0] m20, logic [31:0] m21, logic [31:0] m22);
    cfg_idx_e    idx[5];
    logic [63:0] val[5];
    idx = '{CFG_ROW0_AB, CFG_ROW0_C_ROW1A, CFG_ROW1_BC, CFG_ROW2_AB, CFG_ROW2_C};
    val = '{{m00, m01}, {m02, m10}, {m11, m12}, {m20, m21}, {$urandom(), m22}};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_box(logic [15:0] ox, logic [15:0] oy, logic [15:0] bw,
                          logic [15:0] bh);
    bit hs;
    int g;
    g = send_idle ? $urandom_range(0, 13) : 0;
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= {ox, oy, bw, bh};
    do begin
      @(negedge clk_i) hs = in_if.ready;
      @(posedge clk_i);
    end while (!hs);
  endtask

  task automatic send_random;
    if ($urandom_range(0, 1)) begin
      send_box(16'($signed($urandom_range(0, 2000)) - 1000),
               16'($signed($urandom_range(0, 2000)) - 1000),
               16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)));
    end else begin
      send_box(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
    end
  endtask

  task automatic wait_drained;
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] edges[6];
    cycles      = 0;
    send_idle   = 1'b0;
    recv_idle   = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_ROW0_AB;
    cfg_data_i  = '0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset identity, field extremes and empty sizes
    edges = '{16'h0000, 16'h0001, 16'h7fff, 16'h8000, 16'hffff, 16'h8001};
    for (int i = 0; i < 6; i++) begin
      send_box(edges[i], edges[5 - i], edges[(i + 2) % 6], edges[(i + 3) % 6]);
      send_box(edges[5 - i], edges[i], edges[i], edges[(i + 1) % 6]);
    end
    send_box(16'd10, 16'd20, 16'd0, 16'd5);
    send_box(16'd10, 16'd20, 16'd5, 16'd0);
    send_box(16'd0, 16'd0, 16'd1, 16'd1);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: write_matrix(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
                        32'h0, 32'h0, 32'h1000_0000);
        1: write_matrix(32'h0002_8000, 32'h0000_4000, 32'hfff0_0000, 32'hffff_4000,
                        32'h0002_0000, 32'h0035_0000, 32'h0, 32'h0, 32'h1000_0000);
        2: write_matrix(32'h0001_0000, 32'h0000_2000, 32'h0010_0000, 32'h0000_1000,
                        32'h0000_c000, 32'hffe0_0000, 32'h0000_1000, 32'hffff_f800,
                        32'h1000_0000);
        3: write_matrix($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), 32'h0, 32'h0, 32'h0);
        4: write_matrix(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                        32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff,
                        32'h8000_0000);
        5: write_matrix(32'hffff_0000, 32'h0, 32'h0000_8000, 32'h0, 32'h0000_8000,
                        32'h0, 32'h0, 32'h0, 32'hf000_0000);
        6: write_matrix($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom(), $urandom());
        default: write_matrix($urandom() >> 12, $urandom() >> 14, $urandom(),
                              $urandom() >> 14, $urandom() >> 12, $urandom(),
                              $urandom() >> 18, $urandom() >> 18, 32'h1000_0000);
      endcase
      send_idle = ph % 3 != 0;
      recv_idle = ph % 4 != 1;
      for (int n = 0; n < 215; n++) begin
        if (n == 100) wait_drained();
        if (n % 50 == 0) begin
          send_idle = $urandom_range(0, 2) != 0;
          recv_idle = $urandom_range(0, 2) != 0;
        end
        send_random();
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/pbb_pkg.sv
design/pbb_in_if.sv
design/pbb_out_if.sv
design/pbb_div.sv
design/projective_box_bounds.sv
dv/pbb_checker.sv
dv/tb_projective_box_bounds.sv
